// ----- sv/hbd_pkg.sv -----
// ============================================================================
// hbd_pkg
// Shared types, codes and helpers of the HTTP chunked body decoder.
// ============================================================================
package hbd_pkg;

    // Decoder phase, one-hot.
    typedef enum logic [4:0] {
        PH_SIZE  = 5'b00001,
        PH_LF    = 5'b00010,
        PH_DATA  = 5'b00100,
        PH_TRAIL = 5'b01000,
        PH_DONE  = 5'b10000
    } phase_t;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] HEX_TEN    = 8'd10;
    localparam logic [1:0] TRAIL_SKIP = 2'd2;

    // One result item as it travels through the queue.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       body_end;
    } item_t;

    // Front to queue: one optional item per accepted byte.
    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    // Queue to back: the oldest queued item.
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    // Returns {is_hex, digit value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] diff;
        logic [4:0] res;
        diff = 8'h00;
        res  = 5'b0_0000;
        case (c) inside
            [8'h30:8'h39]:
            begin
                diff = c - CHAR_ZERO;
                res  = {1'b1, diff[3:0]};
            end
            [8'h61:8'h66]:
            begin
                diff = c - CHAR_LOW_A + HEX_TEN;
                res  = {1'b1, diff[3:0]};
            end
            [8'h41:8'h46]:
            begin
                diff = c - CHAR_UP_A + HEX_TEN;
                res  = {1'b1, diff[3:0]};
            end
            default:
            begin
                res = 5'b0_0000;
            end
        endcase
        return res;
    endfunction

endpackage

// ----- sv/hbd_ifs.sv -----
// ============================================================================
// hbd_ifs
// Valid/ready channel interfaces of the HTTP chunked body decoder.
// ============================================================================
interface hbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface hbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       body_end;

    modport source (output valid, output out_byte, output body_end, input ready);
    modport sink   (input valid, input out_byte, input body_end, output ready);
endinterface

interface hbd_cfg_if;
    logic valid;
    logic ready;
    logic chunked_mode;

    modport source (output valid, output chunked_mode, input ready);
    modport sink   (input valid, input chunked_mode, output ready);
endinterface

// ----- sv/hbd_front.sv -----
// ============================================================================
// hbd_front
// Accepts body bytes, tracks the chunk framing and classifies each byte
// as a payload byte, an end marker or framing to be dropped.
// ============================================================================
module hbd_front #(
    parameter int SIZE_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    hbd_in_if.sink          body,
    input  logic            chunked_mode,
    input  logic            queue_full,
    output hbd_pkg::push_t  push
);

    hbd_pkg::phase_t        phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   count_reg, count_next;
    logic                   closed_reg, closed_next;
    logic [1:0]             skip_reg, skip_next;
    logic                   accept;
    logic [4:0]             hex;
    logic [SIZE_BITS-1:0]   count_dec;
    logic [1:0]             skip_dec;

    assign body.ready = !queue_full;
    assign accept     = body.valid && body.ready;
    assign hex        = hbd_pkg::hex_digit(body.data_byte);
    assign count_dec  = count_reg - {{(SIZE_BITS-1){1'b0}}, 1'b1};
    assign skip_dec   = skip_reg - 2'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        closed_next = closed_reg;
        skip_next   = skip_reg;
        push        = '0;

        if (!chunked_mode)
        begin
            push.valid         = 1'b1;
            push.item.out_byte = body.data_byte;
            push.item.body_end = body.end_of_stream;
        end
        else
        begin
            case (phase_reg)
                hbd_pkg::PH_SIZE:
                begin
                    if (body.data_byte == hbd_pkg::CHAR_CR)
                    begin
                        if (count_reg == '0)
                        begin
                            push.valid         = 1'b1;
                            push.item.body_end = 1'b1;
                            phase_next         = hbd_pkg::PH_DONE;
                        end
                        else
                        begin
                            phase_next = hbd_pkg::PH_LF;
                        end
                    end
                    else if (closed_reg || !hex[4])
                    begin
                        closed_next = 1'b1;
                    end
                    else if (count_reg[SIZE_BITS-1 -: 4] != 4'h0)
                    begin
                        // One more digit would overflow, so the size saturates.
                        count_next = '1;
                    end
                    else
                    begin
                        count_next = {count_reg[SIZE_BITS-5:0], hex[3:0]};
                    end
                end
                hbd_pkg::PH_LF:
                begin
                    phase_next  = hbd_pkg::PH_DATA;
                    closed_next = 1'b0;
                end
                hbd_pkg::PH_DATA:
                begin
                    push.valid         = 1'b1;
                    push.item.out_byte = body.data_byte;
                    count_next         = count_dec;
                    if (count_dec == '0)
                    begin
                        phase_next = hbd_pkg::PH_TRAIL;
                        skip_next  = hbd_pkg::TRAIL_SKIP;
                    end
                end
                hbd_pkg::PH_TRAIL:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 2'd0)
                    begin
                        phase_next  = hbd_pkg::PH_SIZE;
                        count_next  = '0;
                        closed_next = 1'b0;
                    end
                end
                hbd_pkg::PH_DONE:
                begin
                    phase_next = hbd_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = hbd_pkg::PH_SIZE;
                end
            endcase
        end

        if (body.end_of_stream)
        begin
            phase_next  = hbd_pkg::PH_SIZE;
            count_next  = '0;
            closed_next = 1'b0;
            skip_next   = 2'd0;
        end

        // Nothing is pushed and nothing moves without a transfer.
        if (!accept)
        begin
            push.valid  = 1'b0;
            phase_next  = phase_reg;
            count_next  = count_reg;
            closed_next = closed_reg;
            skip_next   = skip_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hbd_pkg::PH_SIZE;
            count_reg  <= '0;
            closed_reg <= 1'b0;
            skip_reg   <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            closed_reg <= closed_next;
            skip_reg   <= skip_next;
        end
    end

endmodule

// ----- sv/hbd_fifo.sv -----
// ============================================================================
// hbd_fifo
// Short queue of result items between the front and the back.
// ============================================================================
module hbd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  hbd_pkg::push_t  push,
    input  logic            pop,
    output hbd_pkg::head_t  head,
    output logic            full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hbd_pkg::item_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.item  = mem_reg[rptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && head.valid;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ----- sv/hbd_back.sv -----
// ============================================================================
// hbd_back
// Moves queued result items into the output register and presents them
// on the result channel.
// ============================================================================
module hbd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  hbd_pkg::head_t  head,
    output logic            pop,
    hbd_out_if.source       decoded
);

    logic            valid_reg, valid_next;
    hbd_pkg::item_t  item_reg;

    // The register is refilled whenever an item is queued and the register is empty or being emptied.
    assign pop = head.valid && (!valid_reg || decoded.ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (decoded.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign decoded.valid    = valid_reg;
    assign decoded.out_byte = item_reg.out_byte;
    assign decoded.body_end = item_reg.body_end;

endmodule

// ----- sv/http_chunked_body_decoder.sv -----
// ============================================================================
// http_chunked_body_decoder
// Strips HTTP chunked transfer framing from a body byte stream, or passes
// every byte through when chunked mode is off.
// ============================================================================
//
//  Channel   Direction  Carries                      Transfer when
//  --------  ---------  ---------------------------  -------------------
//  body      in         data_byte, end_of_stream     valid && ready
//  decoded   out        out_byte, body_end           valid && ready
//  cfg       in         chunked_mode                 valid && ready
//
//  One body byte is taken every cycle while the queue is not full; the
//  size line parser does one shift-add or count step per byte.
//  A result passes through the queue and then the output register
//  before it appears on decoded.
//  body.ready drops only while the FIFO_DEPTH entry queue is full.
//  cfg.ready is always high. Reset sets chunked mode and the size line phase.
//
module http_chunked_body_decoder #(
    parameter int SIZE_BITS  = 32,
    parameter int FIFO_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    hbd_in_if.sink      body,
    hbd_out_if.source   decoded,
    hbd_cfg_if.sink     cfg
);

    logic             mode_reg, mode_next;
    hbd_pkg::push_t   push;
    hbd_pkg::head_t   head;
    logic             queue_full;
    logic             pop;

    assign cfg.ready = 1'b1;
    assign mode_next = (cfg.valid && cfg.ready) ? cfg.chunked_mode : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    hbd_front #(
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .body         (body),
        .chunked_mode (mode_reg),
        .queue_full   (queue_full),
        .push         (push)
    );

    hbd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (queue_full)
    );

    hbd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .decoded (decoded)
    );

    // The front never offers an item the queue cannot hold.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !queue_full)
        else $error("item pushed into a full queue");

    // In pass-through mode every accepted byte yields one item.
    a_pass_through_push: assert property (@(posedge clk) disable iff (!rst_n)
        (body.valid && body.ready && !mode_reg) |-> push.valid)
        else $error("pass-through byte produced no item");

    // The back only takes items that are present.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from an empty queue");

    // A popped item is on the output in the next cycle.
    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> decoded.valid)
        else $error("popped item did not reach the output");

endmodule

// ----- verif/tb_http_chunked_body_decoder.sv -----
// ============================================================================
// tb_http_chunked_body_decoder
// Self-checking testbench for the HTTP chunked body decoder. Body bytes are
// driven through the body channel with random gaps. A scoreboard decodes the
// same bytes on its own and compares every decoded transfer with the oldest
// expected byte. The run mixes well-formed chunked bodies, cut-off bodies,
// noise and pass-through stretches, with mode changes in between.
// ============================================================================
module tb_http_chunked_body_decoder;

    localparam int          SIZE_BITS    = 32;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned LONG_STALL   = 80;
    localparam logic [7:0]  LINE_FEED    = 8'h0A;
    localparam logic [7:0]  SEMICOLON    = 8'h3B;
    localparam logic [7:0]  CHAR_F       = 8'h46;

    // Decodes the body stream the same way the block should and holds the
    // decoded bytes that have not been seen on the output yet.
    class decoded_byte_scoreboard;
        logic                 chunked;
        hbd_pkg::phase_t      phase;
        logic [SIZE_BITS-1:0] count;
        logic                 digits_closed;
        logic [1:0]           skip_left;
        hbd_pkg::item_t       decoded_q[$];
        int unsigned          errors;

        function new();
            chunked = 1'b1;
            errors  = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            phase         = hbd_pkg::PH_SIZE;
            count         = '0;
            digits_closed = 1'b0;
            skip_left     = 2'd0;
        endfunction

        function void set_mode(logic m);
            chunked = m;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function void push_result(logic [7:0] b, logic last);
            hbd_pkg::item_t it;
            it.out_byte = b;
            it.body_end = last;
            decoded_q = {decoded_q, it};
        endfunction

        function bit hex_nibble(logic [7:0] c, output logic [3:0] v);
            logic [7:0] d;
            d = 8'h00;
            if (c >= hbd_pkg::CHAR_ZERO && c <= hbd_pkg::CHAR_ZERO + 8'd9)
                d = c - hbd_pkg::CHAR_ZERO;
            else if (c >= hbd_pkg::CHAR_LOW_A && c <= hbd_pkg::CHAR_LOW_A + 8'd5)
                d = c - hbd_pkg::CHAR_LOW_A + hbd_pkg::HEX_TEN;
            else if (c >= hbd_pkg::CHAR_UP_A && c <= hbd_pkg::CHAR_UP_A + 8'd5)
                d = c - hbd_pkg::CHAR_UP_A + hbd_pkg::HEX_TEN;
            else
            begin
                v = 4'h0;
                return 1'b0;
            end
            v = d[3:0];
            return 1'b1;
        endfunction

        function void note_byte(logic [7:0] b, logic eos);
            logic [SIZE_BITS-1:0] cap;
            logic [3:0]           nib;
            bit                   is_hex;
            cap = '1;
            if (!chunked)
                push_result(b, eos);
            else
            begin
                case (phase)
                    hbd_pkg::PH_SIZE:
                    begin
                        if (b == hbd_pkg::CHAR_CR)
                        begin
                            if (count == '0)
                            begin
                                push_result(8'h00, 1'b1);
                                phase = hbd_pkg::PH_DONE;
                            end
                            else
                                phase = hbd_pkg::PH_LF;
                        end
                        else
                        begin
                            is_hex = hex_nibble(b, nib);
                            if (digits_closed || !is_hex)
                                digits_closed = 1'b1;
                            else if (count > (cap >> 4))
                                count = cap;
                            else
                                count = (count << 4) + {{(SIZE_BITS-4){1'b0}}, nib};
                        end
                    end
                    hbd_pkg::PH_LF:
                    begin
                        phase         = hbd_pkg::PH_DATA;
                        digits_closed = 1'b0;
                    end
                    hbd_pkg::PH_DATA:
                    begin
                        push_result(b, 1'b0);
                        count = count - 1'b1;
                        if (count == '0)
                        begin
                            phase     = hbd_pkg::PH_TRAIL;
                            skip_left = hbd_pkg::TRAIL_SKIP;
                        end
                    end
                    hbd_pkg::PH_TRAIL:
                    begin
                        skip_left = skip_left - 2'd1;
                        if (skip_left == 2'd0)
                            clear_stream();
                    end
                    default:
                    begin
                        // Body already ended: the byte is dropped.
                    end
                endcase
            end
            if (eos)
                clear_stream();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(logic [7:0] ob, logic be);
            hbd_pkg::item_t want;
            if (decoded_q.size() == 0)
            begin
                report($sformatf("unexpected transfer out_byte=%02h body_end=%0b", ob, be));
                return;
            end
            want = decoded_q.pop_front();
            if (ob !== want.out_byte)
                report($sformatf("out_byte %02h, expected %02h", ob, want.out_byte));
            if (be !== want.body_end)
                report($sformatf("body_end %0b, expected %0b", be, want.body_end));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    int unsigned cycles;
    int unsigned items_sent;
    bit          no_idle;
    bit          stall_request;
    logic [7:0]  stream_q[$];

    decoded_byte_scoreboard sb = new();

    hbd_in_if  body_ch();
    hbd_out_if decoded_ch();
    hbd_cfg_if cfg_ch();

    http_chunked_body_decoder #(
        .SIZE_BITS(SIZE_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .body   (body_ch),
        .decoded(decoded_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // All transfers are observed here, on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_mode(cfg_ch.chunked_mode);
            if (body_ch.valid && body_ch.ready)
                sb.note_byte(body_ch.data_byte, body_ch.end_of_stream);
            if (decoded_ch.valid && decoded_ch.ready)
                sb.check_result(decoded_ch.out_byte, decoded_ch.body_end);
        end
    end

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    // Receiver: may stall before each transfer, once for a long stretch on request.
    initial
    begin
        int unsigned stall;
        int unsigned k;
        decoded_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (stall_request)
            begin
                stall_request = 1'b0;
                stall = LONG_STALL;
            end
            else
                stall = draw_gap();
            if (stall != 0)
            begin
                decoded_ch.ready = 1'b0;
                for (k = 0; k < stall; k++)
                    @(negedge clk);
            end
            decoded_ch.ready = 1'b1;
            do @(posedge clk); while (!decoded_ch.valid);
            @(negedge clk);
        end
    end

    // Called at a falling edge. Valid stays high after the transfer so that a
    // following byte with no gap goes out back to back.
    task automatic send_byte(logic [7:0] b, logic eos);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            body_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        body_ch.valid         = 1'b1;
        body_ch.data_byte     = b;
        body_ch.end_of_stream = eos;
        do @(posedge clk); while (!body_ch.ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        body_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(logic m);
        wait_drained();
        cfg_ch.valid        = 1'b1;
        cfg_ch.chunked_mode = m;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_queue();
        int i;
        for (i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], i == stream_q.size() - 1);
    endtask

    task automatic append_byte(logic [7:0] b);
        stream_q = {stream_q, b};
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10)
            return hbd_pkg::CHAR_ZERO + v;
        return ($urandom_range(0, 1) ? hbd_pkg::CHAR_UP_A : hbd_pkg::CHAR_LOW_A)
               + v - hbd_pkg::HEX_TEN;
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == hbd_pkg::CHAR_CR);
        return b;
    endfunction

    // Size line: optional leading zeros, mixed-case digits, sometimes an
    // extension after a semicolon, then CR and the skipped byte.
    task automatic add_size_line(int unsigned sz);
        logic [3:0]  nib_q[$];
        int unsigned v;
        v = sz;
        if (sz == 0)
        begin
            case ($urandom_range(0, 5))
                0: ;
                1:
                begin
                    append_byte(hbd_pkg::CHAR_ZERO);
                    append_byte(hbd_pkg::CHAR_ZERO);
                end
                default: append_byte(hbd_pkg::CHAR_ZERO);
            endcase
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) append_byte(hbd_pkg::CHAR_ZERO);
            while (v != 0)
            begin
                nib_q.push_front(v[3:0]);
                v = v >> 4;
            end
            foreach (nib_q[j])
                append_byte(hex_char(nib_q[j]));
        end
        if ($urandom_range(0, 4) == 0)
        begin
            append_byte(SEMICOLON);
            repeat ($urandom_range(1, 4)) append_byte(junk_byte());
        end
        append_byte(hbd_pkg::CHAR_CR);
        append_byte(($urandom_range(0, 7) == 0) ? junk_byte() : LINE_FEED);
    endtask

    task automatic add_chunked_body();
        int unsigned sz;
        repeat ($urandom_range(1, 4))
        begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            add_size_line(sz);
            repeat (sz) append_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) == 0)
                repeat (2) append_byte(8'($urandom_range(0, 255)));
            else
            begin
                append_byte(hbd_pkg::CHAR_CR);
                append_byte(LINE_FEED);
            end
        end
        add_size_line(0);
        repeat ($urandom_range(0, 3)) append_byte(8'($urandom_range(0, 255)));
    endtask

    // Noise leans on hex digits, CR and the characters next to the hex ranges.
    task automatic add_noise();
        logic [7:0] near_hex[6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
        repeat ($urandom_range(3, 20))
        begin
            case ($urandom_range(0, 3))
                0: append_byte(hex_char(4'($urandom_range(0, 15))));
                1: append_byte(hbd_pkg::CHAR_CR);
                2: append_byte(near_hex[$urandom_range(0, 5)]);
                default: append_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // One response: well-formed, cut short by an early end of stream, or noise.
    task automatic send_random_body();
        int unsigned kind;
        int unsigned cut;
        int unsigned flip_at;
        int          i;
        if ($urandom_range(0, 7) == 0)
            write_mode($urandom_range(0, 3) != 0);
        no_idle = ($urandom_range(0, 4) == 0);
        stream_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 85)
            add_chunked_body();
        else
            add_noise();
        cut = stream_q.size();
        if (kind >= 70 && kind < 85)
            cut = $urandom_range(1, stream_q.size());
        flip_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, cut) : cut;
        for (i = 0; i < cut; i++)
        begin
            // A mode change in the middle of a response keeps the decode state.
            if (i == flip_at)
                write_mode(1'($urandom_range(0, 1)));
            send_byte(stream_q[i], i == cut - 1);
        end
    endtask

    initial
    begin
        body_ch.valid         = 1'b0;
        body_ch.data_byte     = 8'h00;
        body_ch.end_of_stream = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.chunked_mode   = 1'b1;
        cycles                = 0;
        items_sent            = 0;
        no_idle               = 1'b0;
        stall_request         = 1'b0;
        rst_n                 = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Extension after a non-hex character, then end of stream on a data byte.
        stream_q = '{8'h31, 8'h67, CHAR_F, hbd_pkg::CHAR_CR, LINE_FEED, 8'hAA};
        send_queue();
        // Empty size line ends the body; the next byte is dropped.
        stream_q = '{hbd_pkg::CHAR_CR, 8'h7A};
        send_queue();
        // Oversized size saturates; the stream is cut after one data byte.
        stream_q.delete();
        repeat (9) append_byte(CHAR_F);
        append_byte(hbd_pkg::CHAR_CR);
        append_byte(LINE_FEED);
        append_byte(8'h12);
        send_queue();
        // Chunk of three with a pass-through byte in the middle.
        send_byte(8'h33, 1'b0);
        send_byte(hbd_pkg::CHAR_CR, 1'b0);
        send_byte(LINE_FEED, 1'b0);
        send_byte(8'h00, 1'b0);
        write_mode(1'b0);
        send_byte(8'h80, 1'b0);
        write_mode(1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(hbd_pkg::CHAR_CR, 1'b0);
        send_byte(LINE_FEED, 1'b1);
        write_mode(1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Back-to-back pass-through bytes against a long output stall.
        no_idle       = 1'b1;
        stall_request = 1'b1;
        repeat (39) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        no_idle = 1'b0;
        write_mode(1'b1);

        while (items_sent < RANDOM_ITEMS + 70)
            send_random_body();

        no_idle = 1'b0;
        wait_drained();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
